### sv/bda_pkg.sv
// Shared types and codes of the banker's allocator.
`timescale 1ns / 1ps
package bda_pkg;
  typedef enum logic [1:0] {
    OP_LOAD_ALLOC = 2'd0,
    OP_LOAD_MAX   = 2'd1,
    OP_LOAD_AVAIL = 2'd2,
    OP_REQUEST    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_GRANTED  = 2'd0,
    ST_EXCEEDS  = 2'd1,
    ST_WAIT     = 2'd2,
    ST_UNSAFE   = 2'd3
  } status_t;

  localparam int unsigned REG_NUM_PROCESSES = 0;
  localparam int unsigned REG_NUM_RESOURCES = 1;
  localparam int unsigned CFG_WIDTH = 5;
  localparam int unsigned CFG_INDEX_WIDTH = 1;

  typedef struct packed {
    logic [1:0] operation;
    logic [3:0] process_id;
    logic [3:0] resource_id;
    logic [7:0] amount;
    logic       last;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] process_id_out;
  } out_word_t;
endpackage

### sv/bda_if.sv
// Valid/ready channel carrying one word of a given type.
`timescale 1ns / 1ps
interface bda_in_if (input logic clk);
  logic valid;
  logic ready;
  bda_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bda_out_if (input logic clk);
  logic valid;
  logic ready;
  bda_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/bankers_deadlock_avoidance.sv
// Banker's algorithm allocator: table loads, requests and safety check.
//
// Usage: words arrive on in_ch (valid/ready). Allocation and maximum load words
// read the table memory, then write the modified entry; available words write avail.
// Request elements are buffered; the element marked last starts the check.
// A completed request gives one word on out_ch: status and process id.
// A request runs in steps: the need/available check over R elements, the
// tentative grant, then the safety check of up to P passes over P rows of
// R elements, adding the allocation of each row that finishes to the work
// vector, and a rollback of the grant if it is unsafe. R = num_resources,
// P = num_processes. The two table memories each have one read port and
// one write port.
// One item is worked at a time; in_ch.ready is low while an item is at work.
// Reset: a clearing pass writes zero to all MAX_PROCS*MAX_RESOURCES entries
// of both tables, one entry per cycle, before any word is taken; config
// registers return to their maximum. A stalled receiver holds the result in
// the output register; the next word is taken meanwhile and runs up to its
// own result.
`timescale 1ns / 1ps
module bankers_deadlock_avoidance #(
  parameter int MAX_PROCS = 16,
  parameter int MAX_RESOURCES = 16,
  parameter int COUNT_BITS = 8
) (
  input  logic clk,
  input  logic rst,
  bda_in_if.sink    in_ch,
  bda_out_if.source out_ch,
  input  logic cfg_we,
  input  logic [bda_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [bda_pkg::CFG_WIDTH-1:0] cfg_data
);
  localparam int PW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int RW = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
  localparam int CELLS = MAX_PROCS * MAX_RESOURCES;
  localparam int AW = $clog2(CELLS);
  localparam int WW = COUNT_BITS + 4;
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
  localparam logic [WW-1:0] WMAX = {WW{1'b1}};
  localparam int PCW = $clog2(MAX_PROCS + 1);
  localparam int RCW = $clog2(MAX_RESOURCES + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_LOAD_RD, S_LOAD_WR,
    S_CHK_RD, S_CHK_EV, S_GNT_RD, S_GNT_WR,
    S_SAF_INIT, S_SAF_RD, S_SAF_EV, S_SAF_ADD_RD, S_SAF_ADD,
    S_RB_RD, S_RB_WR, S_DONE
  } state_t;

  // Table memories: one read and one write per cycle, registered read data.
  logic [COUNT_BITS-1:0] alloc_mem [CELLS];
  logic [COUNT_BITS-1:0] need_mem [CELLS];
  logic [AW-1:0] rd_addr, wr_addr;
  logic alloc_we, need_we;
  logic [COUNT_BITS-1:0] alloc_wd, need_wd, alloc_q, need_q;

  always_ff @(posedge clk) begin
    if (alloc_we) alloc_mem[wr_addr] <= alloc_wd;
    if (need_we) need_mem[wr_addr] <= need_wd;
    alloc_q <= alloc_mem[rd_addr];
    need_q <= need_mem[rd_addr];
  end

  // Small vectors held in flops; mostly read at a counter-selected place (avail is copied whole into work).
  logic [COUNT_BITS-1:0] avail [MAX_RESOURCES];
  logic [COUNT_BITS-1:0] old_avail [MAX_RESOURCES];
  logic [COUNT_BITS-1:0] req_buf [MAX_RESOURCES];
  logic [COUNT_BITS-1:0] old_alloc [MAX_RESOURCES];
  logic [COUNT_BITS-1:0] old_need [MAX_RESOURCES];
  logic [WW-1:0] work [MAX_RESOURCES];
  logic [MAX_PROCS-1:0] finished;
  logic [MAX_RESOURCES-1:0] req_set;

  state_t state;
  logic [PCW-1:0] num_p;
  logic [RCW-1:0] num_r;
  logic [AW:0] clr_cnt;
  logic [RCW-1:0] rcnt;
  logic [PCW-1:0] pcnt, left;
  logic progress, fits, bad_need, bad_avail;
  bda_pkg::in_word_t cur;
  logic [PW-1:0] cur_p;
  logic [RW-1:0] cur_r;
  logic p_ok, r_ok;
  logic out_valid;
  bda_pkg::out_word_t out_data;
  // status of the request at work; moves to out_data once the output is free
  bda_pkg::out_word_t res_word;

  assign p_ok = 32'(cur.process_id) < MAX_PROCS;
  assign r_ok = 32'(cur.resource_id) < MAX_RESOURCES;
  assign cur_p = PW'(cur.process_id);
  assign cur_r = RW'(cur.resource_id);

  assign in_ch.ready = (state == S_IDLE);
  assign out_ch.valid = out_valid;
  assign out_ch.data = out_data;

  function automatic logic [AW-1:0] cell_addr(input logic [PW-1:0] p,
                                               input logic [RW-1:0] r);
    cell_addr = AW'(32'(p) * MAX_RESOURCES + 32'(r));
  endfunction

  logic [COUNT_BITS-1:0] amt;
  assign amt = (32'(cur.amount) > 32'(CMAX)) ? CMAX : COUNT_BITS'(cur.amount);

  logic [RW-1:0] ri;
  logic [PW-1:0] pi;
  assign ri = RW'(rcnt);
  assign pi = PW'(pcnt);

  logic [COUNT_BITS:0] gsum;
  logic [WW:0] wsum;
  assign gsum = {1'b0, alloc_q} + {1'b0, req_buf[ri]};
  assign wsum = {1'b0, work[ri]} + (WW+1)'(alloc_q);

  // Memory port steering.
  always_comb begin
    rd_addr = cell_addr(cur_p, cur_r);
    wr_addr = cell_addr(cur_p, cur_r);
    alloc_we = 1'b0;
    need_we = 1'b0;
    alloc_wd = amt;
    need_wd = '0;
    unique case (state)
      S_CLEAR: begin
        wr_addr = clr_cnt[AW-1:0];
        alloc_we = 1'b1;
        need_we = 1'b1;
        alloc_wd = '0;
      end
      S_LOAD_WR: begin
        alloc_we = (cur.operation == bda_pkg::OP_LOAD_ALLOC) && p_ok && r_ok;
        need_we = (cur.operation == bda_pkg::OP_LOAD_MAX) && p_ok && r_ok;
        need_wd = (amt > alloc_q) ? amt - alloc_q : '0;
      end
      S_CHK_RD, S_GNT_RD, S_RB_RD: rd_addr = cell_addr(cur_p, ri);
      S_GNT_WR: begin
        wr_addr = cell_addr(cur_p, ri);
        alloc_we = 1'b1;
        need_we = 1'b1;
        alloc_wd = gsum[COUNT_BITS] ? CMAX : gsum[COUNT_BITS-1:0];
        need_wd = need_q - req_buf[ri];
      end
      S_SAF_RD, S_SAF_ADD_RD: rd_addr = cell_addr(pi, ri);
      S_RB_WR: begin
        wr_addr = cell_addr(cur_p, ri);
        alloc_we = 1'b1;
        need_we = 1'b1;
        alloc_wd = old_alloc[ri];
        need_wd = old_need[ri];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr_cnt <= '0;
      num_p <= PCW'(MAX_PROCS);
      num_r <= RCW'(MAX_RESOURCES);
      out_valid <= 1'b0;
      finished <= '0;
      req_set <= '0;
      for (int i = 0; i < MAX_RESOURCES; i++) avail[i] <= '0;
    end else begin
      if (out_valid && out_ch.ready && state != S_DONE) out_valid <= 1'b0;
      if (cfg_we) begin
        if (32'(cfg_index) == bda_pkg::REG_NUM_PROCESSES)
          num_p <= (cfg_data == '0) ? PCW'(1) :
                   (32'(cfg_data) > MAX_PROCS) ? PCW'(MAX_PROCS) : PCW'(cfg_data);
        else if (32'(cfg_index) == bda_pkg::REG_NUM_RESOURCES)
          num_r <= (cfg_data == '0) ? RCW'(1) :
                   (32'(cfg_data) > MAX_RESOURCES) ? RCW'(MAX_RESOURCES) : RCW'(cfg_data);
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (32'(clr_cnt) == CELLS - 1) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_ch.valid && in_ch.ready) begin
            cur <= in_ch.data;
            state <= S_LOAD_RD;
          end
        end
        S_LOAD_RD: begin
          // dispatch; memory read of the addressed cell is in flight
          unique case (cur.operation)
            bda_pkg::OP_LOAD_ALLOC, bda_pkg::OP_LOAD_MAX: state <= S_LOAD_WR;
            bda_pkg::OP_LOAD_AVAIL: begin
              if (r_ok) avail[cur_r] <= amt;
              state <= S_IDLE;
            end
            default: begin
              if (r_ok) begin
                req_buf[cur_r] <= amt;
                req_set[cur_r] <= 1'b1;
              end
              if (!cur.last) state <= S_IDLE;
              else if (!p_ok || 32'(cur.process_id) >= 32'(num_p)) begin
                res_word <= '{status: bda_pkg::ST_EXCEEDS, process_id_out: cur.process_id};
                state <= S_DONE;
              end else begin
                rcnt <= '0;
                bad_need <= 1'b0;
                bad_avail <= 1'b0;
                state <= S_CHK_RD;
              end
            end
          endcase
        end
        S_LOAD_WR: state <= S_IDLE;
        S_CHK_RD: begin
          // unwritten elements count as zero
          if (!req_set[ri]) req_buf[ri] <= '0;
          state <= S_CHK_EV;
        end
        S_CHK_EV: begin
          if (req_buf[ri] > need_q) bad_need <= 1'b1;
          if (req_buf[ri] > avail[ri]) bad_avail <= 1'b1;
          if (32'(rcnt) + 1 == 32'(num_r)) begin
            rcnt <= '0;
            if (bad_need || req_buf[ri] > need_q) begin
              res_word <= '{status: bda_pkg::ST_EXCEEDS, process_id_out: cur.process_id};
              state <= S_DONE;
            end else if (bad_avail || req_buf[ri] > avail[ri]) begin
              res_word <= '{status: bda_pkg::ST_WAIT, process_id_out: cur.process_id};
              state <= S_DONE;
            end else state <= S_GNT_RD;
          end else begin
            rcnt <= rcnt + 1'b1;
            state <= S_CHK_RD;
          end
        end
        S_GNT_RD: state <= S_GNT_WR;
        S_GNT_WR: begin
          old_alloc[ri] <= alloc_q;
          old_need[ri] <= need_q;
          old_avail[ri] <= avail[ri];
          avail[ri] <= avail[ri] - req_buf[ri];
          if (32'(rcnt) + 1 == 32'(num_r)) state <= S_SAF_INIT;
          else begin
            rcnt <= rcnt + 1'b1;
            state <= S_GNT_RD;
          end
        end
        S_SAF_INIT: begin
          for (int i = 0; i < MAX_RESOURCES; i++) work[i] <= WW'(avail[i]);
          finished <= '0;
          left <= num_p;
          pcnt <= '0;
          rcnt <= '0;
          progress <= 1'b0;
          fits <= 1'b1;
          state <= S_SAF_RD;
        end
        S_SAF_RD: begin
          // skip finished rows at once
          if (finished[pi]) begin
            if (32'(pcnt) + 1 == 32'(num_p)) begin
              pcnt <= '0;
              if (!progress) begin
                res_word <= '{status: bda_pkg::ST_UNSAFE, process_id_out: cur.process_id};
                rcnt <= '0;
                state <= S_RB_RD;
              end
              progress <= 1'b0;
            end else pcnt <= pcnt + 1'b1;
          end else state <= S_SAF_EV;
        end
        S_SAF_EV: begin
          logic f;
          f = fits && !(WW'(need_q) > work[ri]);
          if (32'(rcnt) + 1 == 32'(num_r)) begin
            rcnt <= '0;
            fits <= 1'b1;
            if (f) state <= S_SAF_ADD_RD;
            else if (32'(pcnt) + 1 == 32'(num_p)) begin
              pcnt <= '0;
              progress <= 1'b0;
              if (!progress) begin
                res_word <= '{status: bda_pkg::ST_UNSAFE, process_id_out: cur.process_id};
                state <= S_RB_RD;
              end else state <= S_SAF_RD;
            end else begin
              pcnt <= pcnt + 1'b1;
              state <= S_SAF_RD;
            end
          end else begin
            fits <= f;
            rcnt <= rcnt + 1'b1;
            state <= S_SAF_RD;
          end
        end
        S_SAF_ADD_RD: state <= S_SAF_ADD;
        S_SAF_ADD: begin
          work[ri] <= wsum[WW] ? WMAX : wsum[WW-1:0];
          if (32'(rcnt) + 1 == 32'(num_r)) begin
            rcnt <= '0;
            finished[pi] <= 1'b1;
            left <= left - 1'b1;
            if (left == PCW'(1)) begin
              res_word <= '{status: bda_pkg::ST_GRANTED, process_id_out: cur.process_id};
              state <= S_DONE;
            end else begin
              progress <= 1'b1;
              if (32'(pcnt) + 1 == 32'(num_p)) begin
                pcnt <= '0;
                progress <= 1'b0;
              end else pcnt <= pcnt + 1'b1;
              state <= S_SAF_RD;
            end
          end else begin
            rcnt <= rcnt + 1'b1;
            state <= S_SAF_ADD_RD;
          end
        end
        S_RB_RD: state <= S_RB_WR;
        S_RB_WR: begin
          avail[ri] <= old_avail[ri];
          if (32'(rcnt) + 1 == 32'(num_r)) state <= S_DONE;
          else begin
            rcnt <= rcnt + 1'b1;
            state <= S_RB_RD;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ch.ready) begin
            out_valid <= 1'b1;
            out_data <= res_word;
            req_set <= '0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Assertions.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ch.ready) else $error("accept while busy");
  a_left_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SAF_RD) |-> (left <= num_p)) else $error("left out of range");
  a_result_after_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DONE)) else $error("stray result");
endmodule
